// ===== hw/rtl/alm_pkg.sv =====
// Shared types, widths and codes of the audio level meter.
package alm_pkg;

  // Field and counter widths
  localparam int COUNT_W     = 32;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 16;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUMSQ_W     = 64;
  localparam int WCHUNK_W    = 8;
  localparam int LTHR_W      = 16;
  localparam int PTHR_W      = 16;
  localparam int RTHR_W      = 15;
  localparam int T2_W        = 2 * RTHR_W;
  localparam int RMS_W       = 20;
  localparam int LOUDH_W     = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Loud share scale (hundredths of a percent)
  localparam int                 SCALE_W     = 14;
  localparam logic [SCALE_W-1:0] LOUD_SCALE  = 14'd10000;
  localparam int                 LOUD_NUM_W  = COUNT_W + SCALE_W;

  // Bit-serial divider: dividend is sumsq with 8 fraction bits
  localparam int FRAC_BITS  = 8;
  localparam int DIV_W      = SUMSQ_W + FRAC_BITS;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Bit-serial square root: two radicand bits per step
  localparam int ROOT_W      = SUMSQ_W / 2;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
  localparam int SQRT_REM_W  = ROOT_W + 2;

  // Whole-unit bits kept before the root; a larger quotient is clamped to all ones
  localparam int QCLAMP_ONES = SUMSQ_W - FRAC_BITS - 1;

  // Register reset values
  localparam logic [WCHUNK_W-1:0] WINDOW_CHUNKS_RST  = 8'd0;
  localparam logic [LTHR_W-1:0]   LOUD_THRESHOLD_RST = 16'd1000;
  localparam logic [PTHR_W-1:0]   PEAK_THRESHOLD_RST = 16'd2000;
  localparam logic [RTHR_W-1:0]   RMS_THRESHOLD_RST  = 15'd40;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_CHUNK_END = 2'd1,
    ACT_FINISH    = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_CHUNKS  = 2'd0,
    CFG_LOUD_THRESHOLD = 2'd1,
    CFG_PEAK_THRESHOLD = 2'd2,
    CFG_RMS_THRESHOLD  = 2'd3
  } cfg_reg_t;

  // Report kinds
  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_TOTAL  = 1'b1;

  // Report sequencer states
  typedef enum logic [2:0] {
    R_IDLE,
    R_LDIV_GO,
    R_LDIV_WAIT,
    R_SDIV_GO,
    R_SDIV_WAIT,
    R_SQRT_GO,
    R_SQRT_WAIT,
    R_DONE
  } rpt_state_t;

  // Figures handed from the accumulators to the report sequencer
  typedef struct packed {
    logic                kind;
    logic [COUNT_W-1:0]  index;
    logic [COUNT_W-1:0]  chunks;
    logic [COUNT_W-1:0]  n;
    logic [MAG_W-1:0]    peak;
    logic [SUMSQ_W-1:0]  sumsq;
    logic [COUNT_W-1:0]  loud;
  } snap_t;

endpackage

// ===== hw/rtl/alm_if.sv =====
// Valid/ready channels of the audio level meter: audio beats in, report beats out.
interface alm_audio_if;
  import alm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface alm_report_if;
  import alm_pkg::*;

  logic               valid;
  logic               ready;
  logic               report_kind;
  logic [COUNT_W-1:0] window_index;
  logic [COUNT_W-1:0] chunk_count;
  logic [COUNT_W-1:0] sample_count;
  logic [MAG_W-1:0]   peak_level;
  logic [RMS_W-1:0]   rms_q4;
  logic [LOUDH_W-1:0] loud_hundredths;
  logic               sound_detected;

  modport source (output valid, report_kind, window_index, chunk_count, sample_count,
                  peak_level, rms_q4, loud_hundredths, sound_detected, input ready);
  modport sink   (input valid, report_kind, window_index, chunk_count, sample_count,
                  peak_level, rms_q4, loud_hundredths, sound_detected, output ready);
endinterface

// ===== hw/rtl/alm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module alm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [alm_pkg::DIV_W-1:0]   dividend,
  input  logic [alm_pkg::COUNT_W-1:0] divisor,
  output logic                        done,
  output logic [alm_pkg::DIV_W-1:0]   quot,
  output logic                        rem_nz
);
  import alm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COUNT_W-1:0]   dvs;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W:0]     rem_sh;
  logic [COUNT_W:0]     rem_sub;
  logic                 ge;

  // Bring down the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem, quot[DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  assign rem_nz = (rem != '0);

  // Shift one bit a cycle until all dividend bits are used
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quot <= dividend;
      end else if (busy) begin
        rem  <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        quot <= {quot[DIV_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/alm_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module alm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [alm_pkg::SUMSQ_W-1:0] radicand,
  output logic                        done,
  output logic [alm_pkg::ROOT_W-1:0]  root
);
  import alm_pkg::*;

  logic                  busy;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [SUMSQ_W-1:0]    x;
  logic [SQRT_REM_W-1:0] rem;
  logic [SQRT_REM_W+1:0] rem_sh;
  logic [SQRT_REM_W+1:0] trial;
  logic [SQRT_REM_W+1:0] rem_sub;
  logic                  take;

  // Bring down two radicand bits and try root*4+1
  always_comb begin
    rem_sh  = {rem, x[SUMSQ_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    take    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  // Advance one root bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x    <= {x[SUMSQ_W-3:0], 2'b00};
        rem  <= take ? rem_sub[SQRT_REM_W-1:0] : rem_sh[SQRT_REM_W-1:0];
        root <= {root[ROOT_W-2:0], take};
        cnt  <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/alm_accum.sv =====
// Input stage and running/window accumulators; hands report figures to the sequencer.
module alm_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [alm_pkg::WCHUNK_W-1:0] window_chunks,
  input  logic [alm_pkg::LTHR_W-1:0]   loud_threshold,
  input  logic                         rpt_busy,
  alm_audio_if.sink                    audio,
  output alm_pkg::snap_t               snap,
  output logic                         snap_valid
);
  import alm_pkg::*;

  // Input stage
  logic               s2_valid;
  action_t            s2_action;
  logic [MAG_W-1:0]   s2_mag;
  logic [SQ_W-1:0]    s2_sq;
  logic               s2_loud;

  // Running totals
  logic [SUMSQ_W-1:0] tot_sumsq;
  logic [COUNT_W-1:0] tot_n;
  logic [COUNT_W-1:0] tot_loud;
  logic [COUNT_W-1:0] tot_chunks;
  logic [MAG_W-1:0]   tot_peak;

  // Window state
  logic [WCHUNK_W-1:0] win_seen;
  logic [SUMSQ_W-1:0]  win_sumsq;
  logic [COUNT_W-1:0]  win_n;
  logic [MAG_W-1:0]    win_peak;
  logic [COUNT_W-1:0]  win_number;

  logic                accept;
  logic [MAG_W-1:0]    mag;
  logic                is_sample;
  logic                is_end;
  logic                is_finish;
  logic                win_close;
  logic                trig;
  logic [WCHUNK_W-1:0] seen_inc;
  logic [SUMSQ_W:0]    tot_sum_raw;
  logic [SUMSQ_W:0]    win_sum_raw;
  logic [SUMSQ_W-1:0]  tot_sumsq_next;
  logic [SUMSQ_W-1:0]  win_sumsq_next;
  logic [COUNT_W-1:0]  tot_n_next;
  logic [COUNT_W-1:0]  win_n_next;
  logic [MAG_W-1:0]    tot_peak_next;
  logic [MAG_W-1:0]    win_peak_next;

  // Magnitude of the two's complement sample
  assign mag    = audio.sample[SAMPLE_W-1] ? (~audio.sample + 1'b1) : audio.sample;
  assign accept = audio.valid && audio.ready;

  // Decode the beat in the input stage
  always_comb begin
    is_sample = s2_valid && (s2_action == ACT_SAMPLE || s2_action == ACT_CHUNK_END);
    is_end    = s2_valid && (s2_action == ACT_CHUNK_END);
    is_finish = s2_valid && (s2_action == ACT_FINISH);
    seen_inc  = (win_seen != '1) ? win_seen + 1'b1 : win_seen;
    win_close = is_end && (window_chunks != '0) && (seen_inc >= window_chunks);
    trig      = win_close || is_finish;
  end

  // Hold off new beats while a report is being formed
  assign audio.ready = !rst && !trig && !snap_valid && !rpt_busy;

  // Saturating updates
  always_comb begin
    tot_sum_raw    = {1'b0, tot_sumsq} + (SUMSQ_W + 1)'(s2_sq);
    win_sum_raw    = {1'b0, win_sumsq} + (SUMSQ_W + 1)'(s2_sq);
    tot_sumsq_next = tot_sum_raw[SUMSQ_W] ? '1 : tot_sum_raw[SUMSQ_W-1:0];
    win_sumsq_next = win_sum_raw[SUMSQ_W] ? '1 : win_sum_raw[SUMSQ_W-1:0];
    tot_n_next     = (tot_n != '1) ? tot_n + 1'b1 : tot_n;
    win_n_next     = (win_n != '1) ? win_n + 1'b1 : win_n;
    tot_peak_next  = (s2_mag > tot_peak) ? s2_mag : tot_peak;
    win_peak_next  = (s2_mag > win_peak) ? s2_mag : win_peak;
  end

  // Register the beat; square and loud test go in with it
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
    if (accept) begin
      s2_action <= action_t'(audio.action);
      s2_mag    <= mag;
      s2_sq     <= mag * mag;
      s2_loud   <= (mag > loud_threshold);
    end
  end

  // Accumulate, close windows, snapshot on reports
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      tot_sumsq  <= '0;
      tot_n      <= '0;
      tot_loud   <= '0;
      tot_chunks <= '0;
      tot_peak   <= '0;
      win_seen   <= '0;
      win_sumsq  <= '0;
      win_n      <= '0;
      win_peak   <= '0;
      win_number <= '0;
    end else begin
      snap_valid <= trig;
      if (is_sample) begin
        tot_sumsq <= tot_sumsq_next;
        tot_n     <= tot_n_next;
        tot_peak  <= tot_peak_next;
        // A closing beat clears the window instead
        if (!win_close) begin
          win_sumsq <= win_sumsq_next;
          win_n     <= win_n_next;
          win_peak  <= win_peak_next;
        end
        if (s2_loud && tot_loud != '1) begin
          tot_loud <= tot_loud + 1'b1;
        end
      end
      if (is_end) begin
        if (tot_chunks != '1) begin
          tot_chunks <= tot_chunks + 1'b1;
        end
        if (window_chunks != '0 && !win_close) begin
          win_seen <= seen_inc;
        end
      end
      if (win_close) begin
        snap.kind   <= KIND_WINDOW;
        snap.index  <= win_number;
        snap.chunks <= COUNT_W'(seen_inc);
        snap.n      <= win_n_next;
        snap.peak   <= win_peak_next;
        snap.sumsq  <= win_sumsq_next;
        snap.loud   <= '0;
        if (win_number != '1) begin
          win_number <= win_number + 1'b1;
        end
        win_seen  <= '0;
        win_sumsq <= '0;
        win_n     <= '0;
        win_peak  <= '0;
      end
      if (is_finish) begin
        snap.kind   <= KIND_TOTAL;
        snap.index  <= '0;
        snap.chunks <= tot_chunks;
        snap.n      <= tot_n;
        snap.peak   <= tot_peak;
        snap.sumsq  <= tot_sumsq;
        snap.loud   <= tot_loud;
        tot_sumsq   <= '0;
        tot_n       <= '0;
        tot_loud    <= '0;
        tot_chunks  <= '0;
        tot_peak    <= '0;
        win_seen    <= '0;
        win_sumsq   <= '0;
        win_n       <= '0;
        win_peak    <= '0;
        win_number  <= '0;
      end
    end
  end
endmodule

// ===== hw/rtl/alm_report.sv =====
// Report sequencer: loud share (total reports) and RMS through the serial divider and root, output register.
module alm_report (
  input  logic                       clk,
  input  logic                       rst,
  input  alm_pkg::snap_t             snap,
  input  logic                       snap_valid,
  input  logic [alm_pkg::PTHR_W-1:0] peak_threshold,
  input  logic [alm_pkg::RTHR_W-1:0] rms_threshold,
  output logic                       busy,
  alm_report_if.source               report
);
  import alm_pkg::*;

  rpt_state_t            state;
  rpt_state_t            state_next;
  snap_t                 cur;
  logic [LOUD_NUM_W-1:0] loud_num;
  logic [T2_W-1:0]       t2;
  logic [LOUDH_W-1:0]    loud_h;
  logic [RMS_W-1:0]      rms;
  logic                  snd;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic                  div_rem_nz;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [ROOT_W-1:0]     sqrt_root;
  logic [SUMSQ_W-1:0]    radicand;
  logic [SUMSQ_W-1:0]    q_whole;
  logic                  frac_nz;
  logic                  snd_calc;
  logic                  out_load;

  alm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cur.n),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  alm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      R_IDLE: begin
        if (snap_valid) begin
          state_next = (snap.kind == KIND_TOTAL) ? R_LDIV_GO : R_SDIV_GO;
        end
      end
      R_LDIV_GO:   state_next = R_LDIV_WAIT;
      R_LDIV_WAIT: if (div_done) state_next = R_SDIV_GO;
      R_SDIV_GO:   state_next = R_SDIV_WAIT;
      R_SDIV_WAIT: if (div_done) state_next = R_SQRT_GO;
      R_SQRT_GO:   state_next = R_SQRT_WAIT;
      R_SQRT_WAIT: if (sqrt_done) state_next = R_DONE;
      R_DONE: begin
        if (!report.valid || report.ready) begin
          state_next = R_IDLE;
        end
      end
      default: state_next = R_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy         = (state != R_IDLE);
    div_start    = (state == R_LDIV_GO) || (state == R_SDIV_GO);
    div_dividend = (state == R_LDIV_GO) ? DIV_W'(loud_num) : {cur.sumsq, {FRAC_BITS{1'b0}}};
    sqrt_start   = (state == R_SQRT_GO);
    out_load     = (state == R_DONE) && (!report.valid || report.ready);
  end

  // Clamp the scaled mean square and test it against the threshold
  always_comb begin
    q_whole  = div_quot[DIV_W-1:FRAC_BITS];
    frac_nz  = (div_quot[FRAC_BITS-1:0] != '0) || div_rem_nz;
    radicand = (div_quot[DIV_W-1:SUMSQ_W-1] != '0)
             ? {1'b0, {QCLAMP_ONES{1'b1}}, div_quot[FRAC_BITS-1:0]}
             : div_quot[SUMSQ_W-1:0];
    snd_calc = (cur.peak > peak_threshold) && (cur.n != '0)
             && ((q_whole > SUMSQ_W'(t2)) || ((q_whole == SUMSQ_W'(t2)) && frac_nz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture figures and intermediate results
  always_ff @(posedge clk) begin
    if (state == R_IDLE && snap_valid) begin
      cur      <= snap;
      loud_num <= LOUD_NUM_W'(snap.loud) * LOUD_NUM_W'(LOUD_SCALE);
      t2       <= T2_W'(rms_threshold) * T2_W'(rms_threshold);
      loud_h   <= '0;
    end
    if (state == R_LDIV_WAIT && div_done) begin
      loud_h <= (cur.n == '0) ? '0 : div_quot[LOUDH_W-1:0];
    end
    if (state == R_SQRT_GO) begin
      snd <= snd_calc;
    end
    if (state == R_SQRT_WAIT && sqrt_done) begin
      rms <= (cur.n == '0) ? '0 : sqrt_root[RMS_W-1:0];
    end
  end

  // Output register: load a finished report, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (out_load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
    if (out_load) begin
      report.report_kind     <= cur.kind;
      report.window_index    <= cur.index;
      report.chunk_count     <= cur.chunks;
      report.sample_count    <= cur.n;
      report.peak_level      <= cur.peak;
      report.rms_q4          <= rms;
      report.loud_hundredths <= loud_h;
      report.sound_detected  <= snd;
    end
  end
endmodule

// ===== hw/rtl/audio_level_meter_unit.sv =====
// Audio level meter top level: configuration registers, accumulators and report sequencer.
//
// Use: audio beats (action, sample) enter on the audio channel, reports leave on the
// report channel; both are valid/ready. Action sample or chunk end updates peak, sum of
// squares and counts; when window_chunks is nonzero, a chunk end that completes
// window_chunks chunks yields a window report. A finish beat yields a total report and
// clears all statistics. Throughput: one sample beat per cycle while ready is high. A
// beat that closes a window or a finish beat holds ready low until its report is formed
// by the bit-serial divider (one division for a window report, two for a total report)
// and the bit-serial square root, and the sequencer has loaded the output register.
// A report passes the input stage, the snapshot register, the report sequencer and the
// output register.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 window_chunks,
// 1 loud_threshold, 2 peak_threshold, 3 rms_threshold); write only while idle.
// Reset (rst, synchronous): statistics cleared, registers to 0/1000/2000/40, no report.
// Receiver stall: the finished report waits in the output register; the block keeps
// accepting sample beats, and the next report waits for the register to empty.
module audio_level_meter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [alm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]  cfg_data,
  alm_audio_if.sink                      audio,
  alm_report_if.source                   report
);
  import alm_pkg::*;

  logic [WCHUNK_W-1:0] window_chunks;
  logic [LTHR_W-1:0]   loud_threshold;
  logic [PTHR_W-1:0]   peak_threshold;
  logic [RTHR_W-1:0]   rms_threshold;
  snap_t               snap;
  logic                snap_valid;
  logic                rpt_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_chunks  <= WINDOW_CHUNKS_RST;
      loud_threshold <= LOUD_THRESHOLD_RST;
      peak_threshold <= PEAK_THRESHOLD_RST;
      rms_threshold  <= RMS_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_CHUNKS:  window_chunks  <= cfg_data[WCHUNK_W-1:0];
        CFG_LOUD_THRESHOLD: loud_threshold <= cfg_data[LTHR_W-1:0];
        CFG_PEAK_THRESHOLD: peak_threshold <= cfg_data[PTHR_W-1:0];
        CFG_RMS_THRESHOLD:  rms_threshold  <= cfg_data[RTHR_W-1:0];
        default: ;
      endcase
    end
  end

  alm_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .window_chunks  (window_chunks),
    .loud_threshold (loud_threshold),
    .rpt_busy       (rpt_busy),
    .audio          (audio),
    .snap           (snap),
    .snap_valid     (snap_valid)
  );

  alm_report u_report (
    .clk            (clk),
    .rst            (rst),
    .snap           (snap),
    .snap_valid     (snap_valid),
    .peak_threshold (peak_threshold),
    .rms_threshold  (rms_threshold),
    .busy           (rpt_busy),
    .report         (report)
  );
endmodule

// ===== hw/rtl/alm_checker.sv =====
// Port-level assertions for the audio level meter, bound to the top level.
module alm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          audio_valid,
  input logic                          audio_ready,
  input logic [1:0]                    audio_action,
  input logic                          report_valid,
  input logic                          report_ready,
  input logic                          report_kind,
  input logic [alm_pkg::COUNT_W-1:0]   window_index,
  input logic [alm_pkg::COUNT_W-1:0]   sample_count,
  input logic [alm_pkg::LOUDH_W-1:0]   loud_hundredths,
  input logic                          sound_detected
);
  import alm_pkg::*;

  // No report comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("report valid after reset");

  // A finish beat stops intake while the total report is formed
  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    (audio_valid && audio_ready && audio_action == ACT_FINISH) |=> !audio_ready)
    else $error("audio beat taken right after finish");

  // Total reports carry window index zero and a share of at most 100 percent
  a_total_fields: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report_kind == KIND_TOTAL)
      |-> (window_index == '0 && loud_hundredths <= LOUDH_W'(LOUD_SCALE)))
    else $error("bad total report fields");

  // A stalled report beat holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report_ready)
      |=> (report_valid && $stable(sample_count) && $stable(sound_detected)))
    else $error("report beat changed while stalled");
endmodule

bind audio_level_meter_unit alm_checker u_alm_checker (
  .clk             (clk),
  .rst             (rst),
  .audio_valid     (audio.valid),
  .audio_ready     (audio.ready),
  .audio_action    (audio.action),
  .report_valid    (report.valid),
  .report_ready    (report.ready),
  .report_kind     (report.report_kind),
  .window_index    (report.window_index),
  .sample_count    (report.sample_count),
  .loud_hundredths (report.loud_hundredths),
  .sound_detected  (report.sound_detected)
);
